// ===== sv/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned CTR_W         = 64;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned COUNTER_BYTES = 8;

  localparam int unsigned TAG_BYTES_DEF   = 16;
  localparam int unsigned MAX_PAYLOAD_DEF = 16384;

  localparam logic [LEN_W-1:0] CAPACITY_RESET = 16'd16384;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index taken from the word address bit
  localparam logic REG_PAYLOAD_CAPACITY = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    K_HEADER  = 3'd0,
    K_PAYLOAD = 3'd1,
    K_TAG     = 3'd2,
    K_SHORT   = 3'd3,
    K_LONG    = 3'd4,
    K_TRUNC   = 3'd5,
    K_END     = 3'd6
  } kind_t;

  typedef enum logic [5:0] {
    PH_LEN_HI  = 6'b000001,
    PH_LEN_LO  = 6'b000010,
    PH_COUNTER = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_TAG     = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_t;

endpackage

// ===== sv/lpf_byte_if.sv =====
// ----------------------------------------------------------------------------
// lpf_byte_if
// Byte stream channel: one stream byte and an end-of-stream mark per transfer.
// ----------------------------------------------------------------------------
interface lpf_byte_if
  import lpf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

// ===== sv/lpf_result_if.sv =====
// ----------------------------------------------------------------------------
// lpf_result_if
// Result channel: one parser event per transfer.
// ----------------------------------------------------------------------------
interface lpf_result_if
  import lpf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic [CTR_W-1:0]  frame_counter;
  logic [LEN_W-1:0]  payload_length;
  logic              frame_last;

  modport source (output valid, output kind, output data_byte, output frame_counter,
                  output payload_length, output frame_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_counter,
                  input payload_length, input frame_last, output ready);
endinterface

// ===== sv/length_prefixed_frame_parser.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Splits a byte stream into frames of a 16-bit big-endian body length, a
// 64-bit big-endian counter, the payload and a TAG_BYTES tag. Reports the
// counter and payload length once the counter is in, passes payload and tag
// bytes with the last tag byte marked, and flags short bodies, over-long
// payloads, truncation and clean ends. A framing error halts the parser until
// reset; input is still taken and dropped. One byte is taken every cycle while
// the result register is free: each byte is parsed into one result register,
// and a new byte is taken whenever that register is empty or being drained in
// the same cycle, so stream ready follows result ready combinationally.
// payload_capacity sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser
  import lpf_pkg::*;
#(
  parameter int unsigned TAG_BYTES   = TAG_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lpf_byte_if.sink              stream,
  lpf_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [LEN_W-1:0] MIN_BODY    = LEN_W'(COUNTER_BYTES + TAG_BYTES);
  localparam logic [LEN_W-1:0] TAG_LEN     = LEN_W'(TAG_BYTES);
  localparam logic [LEN_W-1:0] MAX_PLEN    = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] CTR_LEN     = LEN_W'(COUNTER_BYTES);

  // Configuration
  logic [LEN_W-1:0] payload_capacity;

  // Parser state
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  byte_index, byte_index_next;
  logic [BYTE_W-1:0] len_hi, len_hi_next;
  logic [LEN_W-1:0]  payload_len, payload_len_next;
  logic [CTR_W-1:0]  counter_shift, counter_shift_next;

  // Result register
  logic              res_valid;
  kind_t             res_kind, res_kind_next;
  logic [BYTE_W-1:0] res_data, res_data_next;
  logic [CTR_W-1:0]  res_ctr, res_ctr_next;
  logic [LEN_W-1:0]  res_plen, res_plen_next;
  logic              res_last, res_last_next;
  logic              emit;

  logic              in_fire;
  logic [LEN_W-1:0]  body_word;
  logic [LEN_W-1:0]  plen_calc;
  logic [LEN_W-1:0]  idx_inc;
  logic [CTR_W-1:0]  ctr_shifted;

  assign stream.ready = !res_valid || result.ready;
  assign in_fire      = stream.valid && stream.ready;

  assign body_word   = {len_hi, stream.stream_byte};
  assign plen_calc   = body_word - MIN_BODY;
  assign idx_inc     = byte_index + LEN_W'(1);
  assign ctr_shifted = {counter_shift[CTR_W-BYTE_W-1:0], stream.stream_byte};

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    len_hi_next        = len_hi;
    payload_len_next   = payload_len;
    counter_shift_next = counter_shift;
    emit               = 1'b0;
    res_kind_next      = K_END;
    res_data_next      = '0;
    res_ctr_next       = '0;
    res_plen_next      = '0;
    res_last_next      = 1'b0;

    if (phase != PH_HALT && stream.end_of_stream) begin
      emit = 1'b1;
      if (phase == PH_LEN_HI) begin
        res_kind_next = K_END;
      end else begin
        res_kind_next = K_TRUNC;
        phase_next    = PH_HALT;
      end
    end else begin
      case (phase)
        PH_LEN_HI: begin
          len_hi_next = stream.stream_byte;
          phase_next  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (body_word < MIN_BODY) begin
            emit          = 1'b1;
            res_kind_next = K_SHORT;
            phase_next    = PH_HALT;
          end else if (plen_calc > payload_capacity || plen_calc > MAX_PLEN) begin
            emit          = 1'b1;
            res_kind_next = K_LONG;
            phase_next    = PH_HALT;
          end else begin
            payload_len_next   = plen_calc;
            counter_shift_next = '0;
            byte_index_next    = '0;
            phase_next         = PH_COUNTER;
          end
        end
        PH_COUNTER: begin
          counter_shift_next = ctr_shifted;
          byte_index_next    = idx_inc;
          if (idx_inc >= CTR_LEN) begin
            byte_index_next = '0;
            phase_next      = (payload_len != '0) ? PH_PAYLOAD : PH_TAG;
            emit            = 1'b1;
            res_kind_next   = K_HEADER;
            res_ctr_next    = ctr_shifted;
            res_plen_next   = payload_len;
          end
        end
        PH_PAYLOAD: begin
          byte_index_next = idx_inc;
          if (idx_inc >= payload_len) begin
            byte_index_next = '0;
            phase_next      = PH_TAG;
          end
          emit          = 1'b1;
          res_kind_next = K_PAYLOAD;
          res_data_next = stream.stream_byte;
        end
        PH_TAG: begin
          byte_index_next = idx_inc;
          emit            = 1'b1;
          res_kind_next   = K_TAG;
          res_data_next   = stream.stream_byte;
          if (idx_inc >= TAG_LEN) begin
            byte_index_next = '0;
            phase_next      = PH_LEN_HI;
            res_last_next   = 1'b1;
          end
        end
        default: begin
          // halted: drop everything
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN_HI;
      byte_index    <= '0;
      len_hi        <= '0;
      payload_len   <= '0;
      counter_shift <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        phase         <= phase_next;
        byte_index    <= byte_index_next;
        len_hi        <= len_hi_next;
        payload_len   <= payload_len_next;
        counter_shift <= counter_shift_next;
        res_valid     <= emit;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_kind <= res_kind_next;
      res_data <= res_data_next;
      res_ctr  <= res_ctr_next;
      res_plen <= res_plen_next;
      res_last <= res_last_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.kind           = res_kind;
  assign result.data_byte      = res_data;
  assign result.frame_counter  = res_ctr;
  assign result.payload_length = res_plen;
  assign result.frame_last     = res_last;

  // APB register port
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[APB_ADDR_W-1] == REG_PAYLOAD_CAPACITY) begin
      payload_capacity <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_PAYLOAD_CAPACITY)
                  ? {{(APB_DATA_W-LEN_W){1'b0}}, payload_capacity} : '0;

  // Checks
  a_result_from_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_fire))
    else $error("result appeared without a stream transfer");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left the halted state without reset");

  a_last_only_on_tag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_kind == K_TAG)
    else $error("frame_last on a result that is not the closing tag byte");

  a_counter_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COUNTER |-> byte_index < CTR_LEN)
    else $error("counter byte index out of range");

endmodule
